FILE: rtl/pva_pkg.sv
// Shared types, codes and sizes for the polyphonic voice allocator.
package pva_pkg;

    localparam int VOICES       = 16;
    localparam int TIME_BITS    = 48;
    localparam int VIDX_W       = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SLOT_W       = 4;
    localparam int PITCH_W      = 7;
    localparam int VEL_W        = 7;
    localparam int FRAMES_W     = 16;
    localparam int FIELD_TIME_W = 48;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_NOTE_ON        = 3'd0,
        CMD_NOTE_OFF       = 3'd1,
        CMD_ALL_OFF        = 3'd2,
        CMD_ADVANCE        = 3'd3,
        CMD_VOICE_FINISHED = 3'd4,
        CMD_RESET          = 3'd5,
        CMD_READ_VOICE     = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_BASS = 2'd1,
        KIND_POLY = 2'd2
    } t_kind;

    // Work as the back end sees it, after classification.
    typedef enum logic [3:0] {
        OP_NOTE_ON  = 4'd0,
        OP_REJECT   = 4'd1,
        OP_NOTE_OFF = 4'd2,
        OP_ALL_OFF  = 4'd3,
        OP_ADVANCE  = 4'd4,
        OP_FINISH   = 4'd5,
        OP_RESET    = 4'd6,
        OP_READ     = 4'd7,
        OP_NOP      = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_KILL = 2'd1,
        BK_REL  = 2'd2,
        BK_DONE = 2'd3
    } t_back_state;

    typedef struct packed {
        logic [2:0]          command;
        logic [PITCH_W-1:0]  pitch;
        logic [VEL_W-1:0]    velocity;
        logic [1:0]          kind;
        logic [FRAMES_W-1:0] frames;
        logic [SLOT_W-1:0]   slot;
        logic                glide_on;
    } t_in_word;

    typedef struct packed {
        logic                    status;
        logic [SLOT_W-1:0]       alloc_slot;
        logic                    stolen;
        logic                    glide_valid;
        logic [SLOT_W-1:0]       glide_slot;
        logic                    any_active;
        logic                    rd_active;
        logic                    rd_releasing;
        logic [PITCH_W-1:0]      rd_pitch;
        logic [VEL_W-1:0]        rd_velocity;
        logic [FIELD_TIME_W-1:0] rd_start;
        logic [FIELD_TIME_W-1:0] rd_release;
    } t_out_word;

    typedef struct packed {
        t_op                 op;
        logic [PITCH_W-1:0]  pitch;
        logic [VEL_W-1:0]    velocity;
        logic                is_bass;
        logic                glide_on;
        logic [FRAMES_W-1:0] frames;
        logic [VIDX_W-1:0]   slot;
    } t_job;

endpackage

FILE: rtl/poly_voice_allocator.sv
// Top level of the polyphonic voice allocator: front end, job queue and back end.
// Each command word is decoded on entry and parked in a two-entry job queue; the back end
// then takes it through its steps in order (take from queue, bass-voice kill, same-pitch
// release, allocate and write the result register), walking the sixteen-slot table, and
// takes no new word until the last one is through. The result register lets the next
// word start while a result waits, and the queue keeps accepting words, until it is full,
// while the back end is busy or the output stalls.
module poly_voice_allocator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pva_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pva_pkg::t_out_word o_out_word
);

    pva_pkg::t_job w_front_job;
    pva_pkg::t_job w_head_job;
    logic          w_push;
    logic          w_full;
    logic          w_head_valid;
    logic          w_pop;

    pva_front u_front (
        .i_word  (i_in_word),
        .i_valid (i_in_valid),
        .i_full  (w_full),
        .o_stall (o_in_stall),
        .o_push  (w_push),
        .o_job   (w_front_job)
    );

    pva_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_job   (w_head_job)
    );

    pva_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_head_valid),
        .i_job       (w_head_job),
        .o_job_pop   (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

FILE: rtl/pva_front.sv
// Front end: takes input words and classifies them into jobs for the queue.
module pva_front (
    input  pva_pkg::t_in_word i_word,
    input  logic              i_valid,
    input  logic              i_full,
    output logic              o_stall,
    output logic              o_push,
    output pva_pkg::t_job     o_job
);

    logic w_slot_ok;

    assign o_stall   = i_full;
    assign o_push    = i_valid && !i_full;
    assign w_slot_ok = (int'(i_word.slot) < pva_pkg::VOICES);

    always_comb begin
        o_job.pitch    = i_word.pitch;
        o_job.velocity = (i_word.velocity == '0) ? pva_pkg::VEL_W'(1) : i_word.velocity;
        o_job.is_bass  = (i_word.kind == pva_pkg::KIND_BASS);
        o_job.glide_on = i_word.glide_on;
        o_job.frames   = i_word.frames;
        o_job.slot     = pva_pkg::VIDX_W'(i_word.slot);
        unique case (i_word.command)
            pva_pkg::CMD_NOTE_ON: begin
                o_job.op = (i_word.kind == pva_pkg::KIND_NONE) ? pva_pkg::OP_REJECT
                                                               : pva_pkg::OP_NOTE_ON;
            end
            pva_pkg::CMD_NOTE_OFF:       o_job.op = pva_pkg::OP_NOTE_OFF;
            pva_pkg::CMD_ALL_OFF:        o_job.op = pva_pkg::OP_ALL_OFF;
            pva_pkg::CMD_ADVANCE:        o_job.op = pva_pkg::OP_ADVANCE;
            pva_pkg::CMD_RESET:          o_job.op = pva_pkg::OP_RESET;
            // A slot beyond the table turns into a no-op that still reports.
            pva_pkg::CMD_VOICE_FINISHED: begin
                o_job.op = w_slot_ok ? pva_pkg::OP_FINISH : pva_pkg::OP_NOP;
            end
            pva_pkg::CMD_READ_VOICE: begin
                o_job.op = w_slot_ok ? pva_pkg::OP_READ : pva_pkg::OP_NOP;
            end
            default:                     o_job.op = pva_pkg::OP_NOP;
        endcase
    end

endmodule

FILE: rtl/pva_queue.sv
// Short job queue between the front end and the back end.
module pva_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pva_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output pva_pkg::t_job o_job
);

    pva_pkg::t_job               r_mem [pva_pkg::QUEUE_DEPTH];
    logic [pva_pkg::QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [pva_pkg::QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [pva_pkg::QCNT_W-1:0]  r_count, n_count;
    logic                        w_push, w_pop;

    assign o_full  = (r_count == pva_pkg::QCNT_W'(pva_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == pva_pkg::QPTR_W'(pva_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == pva_pkg::QPTR_W'(pva_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: rtl/pva_back.sv
// Back end: voice slot table, sample clock, job sequencer and result register.
module pva_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  pva_pkg::t_job        i_job,
    output logic                 o_job_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pva_pkg::t_out_word   o_out_word
);

    localparam int V = pva_pkg::VOICES;

    pva_pkg::t_back_state           r_state, n_state;
    pva_pkg::t_job                  r_job, n_job;
    logic [V-1:0]                   r_active, n_active;
    logic [V-1:0]                   r_releasing, n_releasing;
    logic [V-1:0]                   r_bass, n_bass;
    logic [pva_pkg::PITCH_W-1:0]    r_pitch [V];
    logic [pva_pkg::PITCH_W-1:0]    n_pitch [V];
    logic [pva_pkg::VEL_W-1:0]      r_vel [V];
    logic [pva_pkg::VEL_W-1:0]      n_vel [V];
    logic [pva_pkg::TIME_BITS-1:0]  r_start [V];
    logic [pva_pkg::TIME_BITS-1:0]  n_start [V];
    logic [pva_pkg::TIME_BITS-1:0]  r_rel [V];
    logic [pva_pkg::TIME_BITS-1:0]  n_rel [V];
    logic [pva_pkg::TIME_BITS-1:0]  r_time, n_time;
    logic                           r_found, n_found;
    logic [pva_pkg::VIDX_W-1:0]     r_src, n_src;
    logic                           r_out_valid, n_out_valid;
    pva_pkg::t_out_word             r_out, n_out;
    logic [V-1:0]                   w_kill;
    logic [V-1:0]                   w_free;
    logic [pva_pkg::VIDX_W-1:0]     w_dst;
    logic                           w_free_found;

    // Lowest set bit of a slot mask.
    function automatic logic [pva_pkg::VIDX_W-1:0] first_set(input logic [V-1:0] vec);
        logic [pva_pkg::VIDX_W-1:0] idx;
        idx = '0;
        for (int i = V - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = pva_pkg::VIDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign w_kill       = r_active & r_bass;
    assign w_free       = ~r_active;
    assign w_free_found = |w_free;
    assign w_dst        = w_free_found ? first_set(w_free) : '0;

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_active    = r_active;
        n_releasing = r_releasing;
        n_bass      = r_bass;
        n_pitch     = r_pitch;
        n_vel       = r_vel;
        n_start     = r_start;
        n_rel       = r_rel;
        n_time      = r_time;
        n_found     = r_found;
        n_src       = r_src;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_job_pop   = 1'b0;

        unique case (r_state)
            pva_pkg::BK_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_found   = 1'b0;
                    n_src     = '0;
                    n_state   = pva_pkg::BK_KILL;
                end
            end
            pva_pkg::BK_KILL: begin
                // A mono bass note silences every bass voice at once.
                if (r_job.op == pva_pkg::OP_NOTE_ON && r_job.is_bass) begin
                    n_active    = r_active & ~w_kill;
                    n_releasing = r_releasing & ~w_kill;
                    n_found     = |w_kill;
                    n_src       = first_set(w_kill);
                end
                n_state = pva_pkg::BK_REL;
            end
            pva_pkg::BK_REL: begin
                if (r_job.op == pva_pkg::OP_NOTE_ON || r_job.op == pva_pkg::OP_NOTE_OFF) begin
                    for (int i = 0; i < V; i++) begin
                        if (r_active[i] && !r_releasing[i] && r_pitch[i] == r_job.pitch) begin
                            n_releasing[i] = 1'b1;
                            n_rel[i]       = r_time;
                        end
                    end
                end
                n_state = pva_pkg::BK_DONE;
            end
            pva_pkg::BK_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out = '0;
                    case (r_job.op)
                        pva_pkg::OP_NOTE_ON: begin
                            n_active[w_dst]    = 1'b1;
                            n_releasing[w_dst] = 1'b0;
                            n_bass[w_dst]      = r_job.is_bass;
                            n_pitch[w_dst]     = r_job.pitch;
                            n_vel[w_dst]       = r_job.velocity;
                            n_start[w_dst]     = r_time;
                            n_rel[w_dst]       = '0;
                            n_out.alloc_slot   = pva_pkg::SLOT_W'(w_dst);
                            n_out.stolen       = !w_free_found;
                            n_out.glide_valid  = r_found && r_job.glide_on;
                            n_out.glide_slot   = r_found ? pva_pkg::SLOT_W'(r_src) : '0;
                            n_out.rd_active    = 1'b1;
                            n_out.rd_releasing = 1'b0;
                            n_out.rd_pitch     = r_job.pitch;
                            n_out.rd_velocity  = r_job.velocity;
                            n_out.rd_start     = pva_pkg::FIELD_TIME_W'(r_time);
                            n_out.rd_release   = '0;
                        end
                        pva_pkg::OP_REJECT: begin
                            n_out.status = 1'b1;
                        end
                        pva_pkg::OP_ALL_OFF, pva_pkg::OP_RESET: begin
                            for (int i = 0; i < V; i++) begin
                                if (r_active[i] && !r_releasing[i]) begin
                                    n_releasing[i] = 1'b1;
                                    n_rel[i]       = r_time;
                                end
                            end
                            if (r_job.op == pva_pkg::OP_RESET) begin
                                n_time = '0;
                            end
                        end
                        pva_pkg::OP_ADVANCE: begin
                            n_time = r_time + pva_pkg::TIME_BITS'(r_job.frames);
                        end
                        pva_pkg::OP_FINISH: begin
                            n_active[r_job.slot]    = 1'b0;
                            n_releasing[r_job.slot] = 1'b0;
                        end
                        pva_pkg::OP_READ: begin
                            n_out.rd_active    = r_active[r_job.slot];
                            n_out.rd_releasing = r_releasing[r_job.slot];
                            n_out.rd_pitch     = r_pitch[r_job.slot];
                            n_out.rd_velocity  = r_vel[r_job.slot];
                            n_out.rd_start     = pva_pkg::FIELD_TIME_W'(r_start[r_job.slot]);
                            n_out.rd_release   = pva_pkg::FIELD_TIME_W'(r_rel[r_job.slot]);
                        end
                        default: begin
                        end
                    endcase
                    n_out.any_active = |n_active;
                    n_out_valid      = 1'b1;
                    n_state          = pva_pkg::BK_IDLE;
                end
            end
            default: n_state = pva_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pva_pkg::BK_IDLE;
            r_active    <= '0;
            r_releasing <= '0;
            r_bass      <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_releasing <= n_releasing;
            r_bass      <= n_bass;
            r_time      <= n_time;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_found <= n_found;
        r_src   <= n_src;
        r_out   <= n_out;
        r_pitch <= n_pitch;
        r_vel   <= n_vel;
        r_start <= n_start;
        r_rel   <= n_rel;
    end

endmodule

FILE: bench/poly_voice_allocator_tb.sv
// Self-checking testbench for the polyphonic voice allocator.
`timescale 1ns / 1ps

module poly_voice_allocator_tb;
    import pva_pkg::*;

    // Codes that the package enums leave unnamed.
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam logic [1:0] KIND_OTHER = 2'd3;
    localparam int RANDOM_PER_PHASE = 500;

    typedef struct {
        t_in_word  word;
        bit        typed;
        t_out_word result;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    // Mirror of the voice table and the sample clock.
    logic [TIME_BITS-1:0] sample_clk;
    bit                   voice_on      [VOICES];
    bit                   voice_rel     [VOICES];
    bit                   voice_bass    [VOICES];
    bit                   voice_written [VOICES];
    logic [PITCH_W-1:0]   voice_pitch   [VOICES];
    logic [VEL_W-1:0]     voice_vel     [VOICES];
    logic [TIME_BITS-1:0] voice_start   [VOICES];
    logic [TIME_BITS-1:0] voice_end     [VOICES];

    t_out_word expected_results[$];
    t_out_word want_word;
    t_out_word predicted;
    bit        typed_flag = 1'b0;
    t_out_word typed_result = '0;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int mismatches = 0;
    int words_in = 0;
    int results_checked = 0;
    int steals = 0;
    int glides = 0;
    int rejects = 0;

    poly_voice_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    function automatic t_in_word mk_word(logic [2:0] cmd, int pitch, int vel, logic [1:0] kind,
                                         int frames, int slot, bit glide);
        t_in_word w;
        w.command  = cmd;
        w.pitch    = pitch[PITCH_W-1:0];
        w.velocity = vel[VEL_W-1:0];
        w.kind     = kind;
        w.frames   = frames[FRAMES_W-1:0];
        w.slot     = slot[SLOT_W-1:0];
        w.glide_on = glide;
        return w;
    endfunction

    function automatic void release_voice(int v);
        if (voice_on[v] && !voice_rel[v]) begin
            voice_rel[v] = 1'b1;
            voice_end[v] = sample_clk;
        end
    endfunction

    function automatic t_out_word with_readback(t_out_word r, int v);
        r.rd_active    = voice_on[v];
        r.rd_releasing = voice_rel[v];
        r.rd_pitch     = voice_pitch[v];
        r.rd_velocity  = voice_vel[v];
        r.rd_start     = voice_start[v];
        r.rd_release   = voice_end[v];
        return r;
    endfunction

    // Applies one command word to the mirrored table and returns the result word it causes.
    function automatic t_out_word predict_voice_step(t_in_word w);
        t_out_word r;
        bit        bass;
        bit        found;
        bit        free_found;
        int        src;
        int        dst;
        r = '0;
        case (w.command)
            CMD_NOTE_ON: begin
                if (w.kind == KIND_NONE) begin
                    r.status = 1'b1;
                end else begin
                    bass = (w.kind == KIND_BASS);
                    found = 1'b0;
                    src = 0;
                    // A mono bass note silences every bass voice outright.
                    if (bass) begin
                        for (int v = 0; v < VOICES; v++) begin
                            if (voice_on[v] && voice_bass[v]) begin
                                if (!found) begin
                                    found = 1'b1;
                                    src = v;
                                end
                                voice_on[v] = 1'b0;
                                voice_rel[v] = 1'b0;
                            end
                        end
                    end
                    for (int v = 0; v < VOICES; v++) begin
                        if (voice_on[v] && voice_pitch[v] == w.pitch) release_voice(v);
                    end
                    free_found = 1'b0;
                    dst = 0;
                    for (int v = 0; v < VOICES; v++) begin
                        if (!free_found && !voice_on[v]) begin
                            dst = v;
                            free_found = 1'b1;
                        end
                    end
                    voice_on[dst]      = 1'b1;
                    voice_rel[dst]     = 1'b0;
                    voice_written[dst] = 1'b1;
                    voice_pitch[dst]   = w.pitch;
                    voice_vel[dst]     = (w.velocity == '0) ? VEL_W'(1) : w.velocity;
                    voice_bass[dst]    = bass;
                    voice_start[dst]   = sample_clk;
                    voice_end[dst]     = '0;
                    r.alloc_slot  = dst[SLOT_W-1:0];
                    r.stolen      = !free_found;
                    r.glide_valid = found && w.glide_on;
                    r.glide_slot  = found ? src[SLOT_W-1:0] : '0;
                    r = with_readback(r, dst);
                end
            end
            CMD_NOTE_OFF: begin
                for (int v = 0; v < VOICES; v++) begin
                    if (voice_on[v] && voice_pitch[v] == w.pitch) release_voice(v);
                end
            end
            CMD_ALL_OFF, CMD_RESET: begin
                for (int v = 0; v < VOICES; v++) release_voice(v);
                if (w.command == CMD_RESET) sample_clk = '0;
            end
            CMD_ADVANCE: begin
                sample_clk = sample_clk + TIME_BITS'(w.frames);
            end
            CMD_VOICE_FINISHED: begin
                voice_on[w.slot] = 1'b0;
                voice_rel[w.slot] = 1'b0;
            end
            CMD_READ_VOICE: begin
                r = with_readback(r, int'(w.slot));
            end
            default: begin
            end
        endcase
        for (int v = 0; v < VOICES; v++) begin
            if (voice_on[v]) r.any_active = 1'b1;
        end
        return r;
    endfunction

    task automatic compare_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Results are checked before the word accepted on the same edge is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result word with nothing expected, actual %0h",
                             $time, o_out_word);
                    mismatches++;
                end else begin
                    want_word = expected_results.pop_front();
                    compare_field("status", 48'(want_word.status), 48'(o_out_word.status));
                    compare_field("alloc_slot", 48'(want_word.alloc_slot),
                                  48'(o_out_word.alloc_slot));
                    compare_field("stolen", 48'(want_word.stolen), 48'(o_out_word.stolen));
                    compare_field("glide_valid", 48'(want_word.glide_valid),
                                  48'(o_out_word.glide_valid));
                    compare_field("glide_slot", 48'(want_word.glide_slot),
                                  48'(o_out_word.glide_slot));
                    compare_field("any_active", 48'(want_word.any_active),
                                  48'(o_out_word.any_active));
                    compare_field("rd_active", 48'(want_word.rd_active),
                                  48'(o_out_word.rd_active));
                    compare_field("rd_releasing", 48'(want_word.rd_releasing),
                                  48'(o_out_word.rd_releasing));
                    compare_field("rd_pitch", 48'(want_word.rd_pitch),
                                  48'(o_out_word.rd_pitch));
                    compare_field("rd_velocity", 48'(want_word.rd_velocity),
                                  48'(o_out_word.rd_velocity));
                    compare_field("rd_start", want_word.rd_start, o_out_word.rd_start);
                    compare_field("rd_release", want_word.rd_release, o_out_word.rd_release);
                    results_checked++;
                end
            end
            if (i_in_valid === 1'b1 && o_in_stall === 1'b0) begin
                predicted = predict_voice_step(i_in_word);
                expected_results.push_back(typed_flag ? typed_result : predicted);
                words_in++;
                if (predicted.stolen) steals++;
                if (predicted.glide_valid) glides++;
                if (predicted.status) rejects++;
            end
        end
    end

    // Presents one word, with an optional hand-written result, and returns once it is taken.
    task automatic send(t_in_word w, bit typed, t_out_word result);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_word    <= w;
        typed_flag   <= typed;
        typed_result <= result;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
    endtask

    initial begin
        t_row        rows[$];
        t_row        row;
        t_in_word    w;
        t_out_word   e;
        logic [63:0] bits;
        int          pick;
        int          k;
        int          v;
        int          tries;

        sample_clk = '0;
        for (int i = 0; i < VOICES; i++) begin
            voice_on[i] = 1'b0;
            voice_rel[i] = 1'b0;
            voice_bass[i] = 1'b0;
            voice_written[i] = 1'b0;
            voice_pitch[i] = '0;
            voice_vel[i] = '0;
            voice_start[i] = '0;
            voice_end[i] = '0;
        end

        // Directed table. Only the opening rows carry a hand-written result.
        e = '0;
        row.typed = 1'b1;
        row.result = e;
        row.word = mk_word(CMD_ALL_OFF, 0, 0, KIND_NONE, 0, 0, 0);
        rows.push_back(row);
        row.word = mk_word(CMD_ADVANCE, 0, 0, KIND_NONE, 16'hFFFF, 0, 0);
        rows.push_back(row);
        e.status = 1'b1;
        row.result = e;
        row.word = mk_word(CMD_NOTE_ON, 127, 127, KIND_NONE, 16'hFFFF, 15, 1);
        rows.push_back(row);
        e = '0;
        e.any_active = 1'b1;
        e.rd_active = 1'b1;
        e.rd_velocity = VEL_W'(1);
        e.rd_start = 48'hFFFF;
        row.result = e;
        row.word = mk_word(CMD_NOTE_ON, 0, 0, KIND_POLY, 0, 0, 0);
        rows.push_back(row);
        e.alloc_slot = SLOT_W'(1);
        e.rd_pitch = PITCH_W'(127);
        e.rd_velocity = VEL_W'(127);
        row.result = e;
        row.word = mk_word(CMD_NOTE_ON, 127, 127, KIND_BASS, 0, 0, 1);
        rows.push_back(row);
        row.typed = 1'b0;
        row.result = '0;
        row.word = mk_word(CMD_NOTE_ON, 60, 64, KIND_BASS, 0, 0, 1);
        rows.push_back(row);
        row.word = mk_word(CMD_NOTE_ON, 0, 5, KIND_OTHER, 0, 0, 1);
        rows.push_back(row);
        row.word = mk_word(CMD_READ_VOICE, 0, 0, KIND_NONE, 0, 0, 0);
        rows.push_back(row);
        row.word = mk_word(CMD_NOTE_OFF, 60, 0, KIND_NONE, 0, 0, 0);
        rows.push_back(row);
        row.word = mk_word(CMD_ADVANCE, 0, 0, KIND_NONE, 0, 0, 0);
        rows.push_back(row);
        row.word = mk_word(CMD_VOICE_FINISHED, 0, 0, KIND_NONE, 0, 0, 0);
        rows.push_back(row);
        row.word = mk_word(CMD_UNUSED, 127, 127, KIND_OTHER, 16'hFFFF, 15, 1);
        rows.push_back(row);
        row.word = mk_word(CMD_RESET, 0, 0, KIND_NONE, 0, 0, 0);
        rows.push_back(row);
        row.word = mk_word(CMD_ADVANCE, 0, 0, KIND_NONE, 1, 0, 0);
        rows.push_back(row);
        row.word = mk_word(CMD_NOTE_ON, 60, 100, KIND_BASS, 0, 0, 0);
        rows.push_back(row);
        row.word = mk_word(CMD_READ_VOICE, 0, 0, KIND_NONE, 0, 1, 0);
        rows.push_back(row);
        row.word = mk_word(CMD_VOICE_FINISHED, 0, 0, KIND_NONE, 0, 15, 0);
        rows.push_back(row);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send(rows[i].word, rows[i].typed, rows[i].result);

        // Random part: mostly note traffic on a busy table, so steals and bass kills
        // come up often, with stray note-offs, finishes of idle slots and odd commands.
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = (ph == 1) ? 76 : (ph == 3) ? 37 : 0;
            sink_stall_pct = (ph == 2) ? 76 : (ph == 3) ? 37 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                bits = {$urandom, $urandom};
                w = bits[$bits(t_in_word)-1:0];
                pick = $urandom_range(0, 99);
                v = $urandom_range(0, VOICES - 1);
                if (pick < 40 || pick >= 97) begin
                    w.command = CMD_NOTE_ON;
                    k = $urandom_range(0, 99);
                    if (pick >= 97 || k < 4) w.kind = KIND_NONE;
                    else if (k < 35) w.kind = KIND_BASS;
                    else if (k < 90) w.kind = KIND_POLY;
                    else w.kind = KIND_OTHER;
                    if ($urandom_range(0, 99) < 40 && voice_on[v]) w.pitch = voice_pitch[v];
                    if ($urandom_range(0, 9) == 0) w.velocity = '0;
                end else if (pick < 52) begin
                    w.command = CMD_NOTE_OFF;
                    if ($urandom_range(0, 9) < 7 && voice_on[v]) w.pitch = voice_pitch[v];
                end else if (pick < 64) begin
                    w.command = CMD_ADVANCE;
                    k = $urandom_range(0, 9);
                    if (k == 0) w.frames = '0;
                    else if (k == 1) w.frames = '1;
                end else if (pick < 76) begin
                    w.command = CMD_VOICE_FINISHED;
                    for (tries = 0; tries < 4 && !voice_on[w.slot]; tries++) begin
                        w.slot = SLOT_W'($urandom_range(0, VOICES - 1));
                    end
                end else if (pick < 88) begin
                    // Never read a slot that no note has written yet.
                    w.command = CMD_READ_VOICE;
                    for (tries = 0; tries < 16 && !voice_written[w.slot]; tries++) begin
                        w.slot = SLOT_W'($urandom_range(0, VOICES - 1));
                    end
                    if (!voice_written[w.slot]) w.command = CMD_ADVANCE;
                end else if (pick < 93) begin
                    w.command = CMD_ALL_OFF;
                end else if (pick < 95) begin
                    w.command = CMD_RESET;
                end else begin
                    w.command = CMD_UNUSED;
                end
                send(w, 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        sink_stall_pct = 0;
        repeat (20) @(posedge i_clk);

        $display("Drove %0d command words and checked %0d results over four idle/stall mixes.",
                 words_in, results_checked);
        $display("Saw %0d slot steals, %0d bass glides and %0d rejected note-ons.",
                 steals, glides, rejects);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/pva_pkg.sv
rtl/pva_front.sv
rtl/pva_queue.sv
rtl/pva_back.sv
rtl/poly_voice_allocator.sv
bench/poly_voice_allocator_tb.sv
